/* sv/expression_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// expression_tokenizer_defines
// Assertion macros shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKENIZER_DEFINES_SVH
`define EXPRESSION_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked every cycle outside reset
`define EXPTOK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define EXPTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`else

`define EXPTOK_ASSERT(label, clk, rst, prop, msg)
`define EXPTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/exptok_pkg.sv */
// ----------------------------------------------------------------------------
// exptok_pkg
// Token kinds, character codes and token / queue entry types of the
// expression tokenizer.
// ----------------------------------------------------------------------------
package exptok_pkg;

   // result field widths
   localparam int NUMBER_OUT_W = 32;
   localparam int NAME_OUT_W   = 40;
   localparam int LEN_OUT_W    = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   typedef enum logic [2:0] {
      KIND_NUMBER   = 3'd0,
      KIND_VARIABLE = 3'd1,
      KIND_FUNCTION = 3'd2,
      KIND_OPERATOR = 3'd3,
      KIND_OPEN     = 3'd4,
      KIND_CLOSE    = 3'd5,
      KIND_MODULE   = 3'd6,
      KIND_ERROR    = 3'd7
   } kind_type;

   // operator priorities
   localparam logic [2:0] PRIO_NONE = 3'd0;
   localparam logic [2:0] PRIO_ADD  = 3'd1;
   localparam logic [2:0] PRIO_MUL  = 3'd2;
   localparam logic [2:0] PRIO_POW  = 3'd3;
   localparam logic [2:0] PRIO_FUNC = 3'd5;

   // character codes
   localparam logic [7:0] CHAR_ZERO       = "0";
   localparam logic [7:0] CHAR_NINE       = "9";
   localparam logic [7:0] CHAR_LOWER_A    = "a";
   localparam logic [7:0] CHAR_LOWER_Z    = "z";
   localparam logic [7:0] CHAR_UPPER_A    = "A";
   localparam logic [7:0] CHAR_UPPER_Z    = "Z";
   localparam logic [7:0] CHAR_UNDERSCORE = "_";
   localparam logic [7:0] CHAR_PLUS       = "+";
   localparam logic [7:0] CHAR_MINUS      = "-";
   localparam logic [7:0] CHAR_STAR       = "*";
   localparam logic [7:0] CHAR_SLASH      = "/";
   localparam logic [7:0] CHAR_CARET      = "^";
   localparam logic [7:0] CHAR_PAREN_L    = "(";
   localparam logic [7:0] CHAR_PAREN_R    = ")";
   localparam logic [7:0] CHAR_SQUARE_L   = "[";
   localparam logic [7:0] CHAR_SQUARE_R   = "]";
   localparam logic [7:0] CHAR_CURLY_L    = "{";
   localparam logic [7:0] CHAR_CURLY_R    = "}";
   localparam logic [7:0] CHAR_BAR        = "|";

   // function names, first character in the high byte
   localparam logic [23:0] NAME_SIN = "sin";
   localparam logic [23:0] NAME_COS = "cos";
   localparam logic [23:0] NAME_TG  = {"tg", 8'h00};

   typedef struct packed {
      kind_type                  kind;
      logic [NUMBER_OUT_W-1:0]   number_value;
      logic                      overflow;
      logic [NAME_OUT_W-1:0]     name_chars;
      logic [LEN_OUT_W-1:0]      name_length;
      logic [7:0]                symbol;
      logic [2:0]                priority_res;
   } tok_type;

   // one queue entry: the tokens caused by one character
   typedef struct packed {
      tok_type first_tok;
      tok_type second_tok;
      logic    two_tok;
      logic    expr_end;
   } entry_type;

   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

/* sv/expression_tokenizer.sv */
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer for arithmetic expressions: characters in, tokens out.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// req_    | in  | req_valid/req_ready  | char_code, end_of_expr
// rsp_    | out | rsp_valid/rsp_ready  | token_kind .. priority_res, run_last, expr_last
//
// A character is taken every cycle while the two-entry token queue has room.
// Each token takes one result transfer, so a character that makes two tokens
// takes two transfers on the result side; the output register sets that pace.
// First token of a character passes the queue slot, then the output register, to rsp_.
// Reset (synchronous) returns the lexer to the start of an expression and
// empties the queue. A stall on rsp_ready fills the queue, then drops req_ready.
// ----------------------------------------------------------------------------
module expression_tokenizer
   import exptok_pkg::*;
#(
   parameter int MAX_NAME_CHARS = 5,
   parameter int NUMBER_BITS    = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_code,
   input  logic                    req_end_of_expr,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_token_kind,
   output logic [NUMBER_OUT_W-1:0] rsp_number_value,
   output logic                    rsp_overflow,
   output logic [NAME_OUT_W-1:0]   rsp_name_chars,
   output logic [LEN_OUT_W-1:0]    rsp_name_length,
   output logic [7:0]              rsp_symbol,
   output logic [2:0]              rsp_priority_res,
   output logic                    rsp_run_last,
   output logic                    rsp_expr_last
);

   logic      req_accept;
   logic      push, pop;
   entry_type push_entry, head;
   qstat_type q_stat;
   tok_type   rsp_tok;

   // character transfer
   assign req_ready  = !q_stat.full;
   assign req_accept = req_valid && req_ready;

   exptok_front #(
      .MAX_NAME_CHARS (MAX_NAME_CHARS),
      .NUMBER_BITS    (NUMBER_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_char_code   (req_char_code),
      .req_end_of_expr (req_end_of_expr),
      .push            (push),
      .push_entry      (push_entry)
   );

   exptok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_stat     (q_stat),
      .head       (head)
   );

   exptok_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .head          (head),
      .pop           (pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_tok       (rsp_tok),
      .rsp_run_last  (rsp_run_last),
      .rsp_expr_last (rsp_expr_last)
   );

   // token fields onto the result ports
   assign rsp_token_kind   = rsp_tok.kind;
   assign rsp_number_value = rsp_tok.number_value;
   assign rsp_overflow     = rsp_tok.overflow;
   assign rsp_name_chars   = rsp_tok.name_chars;
   assign rsp_name_length  = rsp_tok.name_length;
   assign rsp_symbol       = rsp_tok.symbol;
   assign rsp_priority_res = rsp_tok.priority_res;

endmodule

/* sv/exptok_front.sv */
// ----------------------------------------------------------------------------
// exptok_front
// Lexer front end: classifies each character, keeps the number and name
// scan state and forms the tokens that the character causes.
// ----------------------------------------------------------------------------
`include "expression_tokenizer_defines.svh"

module exptok_front
   import exptok_pkg::*;
#(
   parameter int MAX_NAME_CHARS = 5,
   parameter int NUMBER_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_expr,
   output logic       push,
   output entry_type  push_entry
);

   localparam int NAME_W = 8 * MAX_NAME_CHARS;
   localparam int CNT_W  = $clog2(MAX_NAME_CHARS + 1);
   localparam int NB     = NUMBER_BITS;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_NAME
   } mode_type;

   // pack up to three characters the way the name buffer holds them
   function automatic logic [NAME_W-1:0] pack_name(input logic [23:0] s, input int n);
      logic [NAME_W-1:0] v;
      v = '0;
      for (int i = 0; i < MAX_NAME_CHARS && i < 3; i++) begin
         if (i < n) v[NAME_W-1-8*i -: 8] = s[23-8*i -: 8];
      end
      return v;
   endfunction

   localparam logic [NAME_W-1:0] SIN_PACK = pack_name(NAME_SIN, 3);
   localparam logic [NAME_W-1:0] COS_PACK = pack_name(NAME_COS, 3);
   localparam logic [NAME_W-1:0] TG_PACK  = pack_name(NAME_TG, 2);

   function automatic tok_type number_tok(input logic [NB-1:0] acc, input logic ovf);
      tok_type t;
      logic [NB+NUMBER_OUT_W-1:0] wide;
      t = '0;
      wide = {{NUMBER_OUT_W{1'b0}}, acc};
      t.kind = KIND_NUMBER;
      t.number_value = wide[NUMBER_OUT_W-1:0];
      t.overflow = ovf;
      return t;
   endfunction

   function automatic tok_type name_tok(input logic [NAME_W-1:0] b,
                                        input logic [CNT_W-1:0] c,
                                        input logic too_long);
      tok_type t;
      logic [NAME_W+NAME_OUT_W-1:0] wide_name;
      logic [CNT_W+LEN_OUT_W-1:0]   wide_len;
      t = '0;
      wide_name = {{NAME_OUT_W{1'b0}}, b};
      wide_len = {{LEN_OUT_W{1'b0}}, c};
      t.name_chars = wide_name[NAME_OUT_W-1:0];
      t.name_length = wide_len[LEN_OUT_W-1:0];
      if (too_long) begin
         t.kind = KIND_ERROR;
      end else if ((c == CNT_W'(3) && (b == SIN_PACK || b == COS_PACK)) ||
                   (c == CNT_W'(2) && b == TG_PACK)) begin
         t.kind = KIND_FUNCTION;
         t.priority_res = PRIO_FUNC;
      end else begin
         t.kind = KIND_VARIABLE;
      end
      return t;
   endfunction

   function automatic tok_type single_tok(input logic [7:0] c);
      tok_type t;
      t = '0;
      t.symbol = c;
      case (c) inside
         CHAR_PLUS, CHAR_MINUS: begin
            t.kind = KIND_OPERATOR;
            t.priority_res = PRIO_ADD;
         end
         CHAR_STAR, CHAR_SLASH: begin
            t.kind = KIND_OPERATOR;
            t.priority_res = PRIO_MUL;
         end
         CHAR_CARET: begin
            t.kind = KIND_OPERATOR;
            t.priority_res = PRIO_POW;
         end
         CHAR_PAREN_L, CHAR_SQUARE_L, CHAR_CURLY_L: t.kind = KIND_OPEN;
         CHAR_PAREN_R, CHAR_SQUARE_R, CHAR_CURLY_R: t.kind = KIND_CLOSE;
         CHAR_BAR: t.kind = KIND_MODULE;
         default: t.kind = KIND_ERROR;
      endcase
      return t;
   endfunction

   mode_type           mode_ff, mode_in, mode_mid;
   logic [NB-1:0]      acc_ff, acc_step;
   logic               ovf_ff, ovf_step;
   logic [NAME_W-1:0]  buf_ff, buf_step, buf_base;
   logic [CNT_W-1:0]   cnt_ff, cnt_step, cnt_base;
   logic               long_ff, long_step, long_base;
   kind_type           prev_ff, prev_in;

   logic               is_digit, is_alpha;
   logic [NB-1:0]      num_base;
   logic               ovf_base;
   logic [NB+3:0]      num_prod;
   logic               num_sat;
   logic               hold_num, hold_name, handled;
   logic               flush_v, zero_v, single_v, end_v, any_tok;
   tok_type            flush_t, zero_t, single_t, end_t;

   // character classes
   assign is_digit = req_char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_alpha = (req_char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) ||
                     (req_char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ||
                     (req_char_code == CHAR_UNDERSCORE);

   // number accumulate: acc * 10 + digit, saturating
   assign num_base = (mode_ff == MODE_NUMBER) ? acc_ff : '0;
   assign ovf_base = (mode_ff == MODE_NUMBER) ? ovf_ff : 1'b0;
   assign num_prod = ({4'b0, num_base} << 3) + ({4'b0, num_base} << 1) +
                     {{NB{1'b0}}, req_char_code[3:0]};
   assign num_sat  = |num_prod[NB+3:NB];
   assign acc_step = num_sat ? '1 : num_prod[NB-1:0];
   assign ovf_step = num_sat | ovf_base;

   // name append, extra characters only mark the name as too long
   assign buf_base  = (mode_ff == MODE_NAME) ? buf_ff : '0;
   assign cnt_base  = (mode_ff == MODE_NAME) ? cnt_ff : '0;
   assign long_base = (mode_ff == MODE_NAME) ? long_ff : 1'b0;

   always_comb begin
      buf_step  = buf_base;
      cnt_step  = cnt_base;
      long_step = long_base;
      if (cnt_base < CNT_W'(MAX_NAME_CHARS)) begin
         for (int i = 0; i < MAX_NAME_CHARS; i++) begin
            if (cnt_base == CNT_W'(i)) buf_step[NAME_W-1-8*i -: 8] = req_char_code;
         end
         cnt_step = cnt_base + 1'b1;
      end else begin
         long_step = 1'b1;
      end
   end

   // token candidates in emission order
   assign hold_num  = (mode_ff == MODE_NUMBER) && is_digit;
   assign hold_name = (mode_ff == MODE_NAME) && (is_digit || is_alpha);
   assign handled   = hold_num || hold_name;
   assign flush_v   = (mode_ff == MODE_NUMBER && !is_digit) ||
                      (mode_ff == MODE_NAME && !is_digit && !is_alpha);
   assign flush_t   = (mode_ff == MODE_NUMBER) ? number_tok(acc_ff, ovf_ff)
                                               : name_tok(buf_ff, cnt_ff, long_ff);

   always_comb begin
      if (handled) mode_mid = mode_ff;
      else if (is_digit) mode_mid = MODE_NUMBER;
      else if (is_alpha) mode_mid = MODE_NAME;
      else mode_mid = MODE_IDLE;
   end

   assign single_v = !handled && !is_digit && !is_alpha;
   assign single_t = single_tok(req_char_code);
   // a minus at the start, after an open bracket or after a module symbol
   assign zero_v   = single_v && !flush_v && (req_char_code == CHAR_MINUS) &&
                     (prev_ff == KIND_OPEN || prev_ff == KIND_MODULE);
   assign zero_t   = number_tok('0, 1'b0);
   assign end_v    = req_end_of_expr && (mode_mid != MODE_IDLE);
   assign end_t    = (mode_mid == MODE_NUMBER) ? number_tok(acc_step, ovf_step)
                                               : name_tok(buf_step, cnt_step, long_step);
   assign any_tok  = flush_v || zero_v || single_v || end_v;

   // pack the at most two tokens into one queue entry
   always_comb begin
      push_entry = '0;
      push_entry.expr_end = req_end_of_expr;
      if (flush_v) begin
         push_entry.first_tok  = flush_t;
         push_entry.second_tok = single_v ? single_t : end_t;
         push_entry.two_tok    = single_v || end_v;
      end else if (zero_v) begin
         push_entry.first_tok  = zero_t;
         push_entry.second_tok = single_t;
         push_entry.two_tok    = 1'b1;
      end else if (single_v) begin
         push_entry.first_tok  = single_t;
      end else begin
         push_entry.first_tok  = end_t;
      end
   end

   assign push = req_accept && any_tok;

   // next scan state
   always_comb begin
      mode_in = mode_ff;
      prev_in = prev_ff;
      if (req_accept) begin
         if (req_end_of_expr) begin
            mode_in = MODE_IDLE;
            prev_in = KIND_OPEN;
         end else begin
            mode_in = mode_mid;
            if (any_tok) begin
               prev_in = push_entry.two_tok ? push_entry.second_tok.kind
                                            : push_entry.first_tok.kind;
            end
         end
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         prev_ff <= KIND_OPEN;
      end else begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
      end
   end

   // accumulators, only read while their mode is active
   always_ff @(posedge clock) begin
      if (req_accept) begin
         acc_ff  <= acc_step;
         ovf_ff  <= ovf_step;
         buf_ff  <= buf_step;
         cnt_ff  <= cnt_step;
         long_ff <= long_step;
      end
   end

   `EXPTOK_ASSERT_NEXT(a_end_restarts, clock, reset, req_accept && req_end_of_expr, mode_ff == MODE_IDLE && prev_ff == KIND_OPEN, "scan state not restarted after final character")
   `EXPTOK_ASSERT(a_push_on_accept, clock, reset, push |-> req_accept, "token entry pushed without a character transfer")

endmodule

/* sv/exptok_queue.sv */
// ----------------------------------------------------------------------------
// exptok_queue
// Two-entry queue of token entries between the front and back ends.
// ----------------------------------------------------------------------------
`include "expression_tokenizer_defines.svh"

module exptok_queue
   import exptok_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output qstat_type q_stat,
   output entry_type head
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.valid = (count_ff != '0);
   assign head         = slot_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   `EXPTOK_ASSERT(a_no_push_full, clock, reset, push |-> !q_stat.full || pop, "push into full queue")
   `EXPTOK_ASSERT(a_no_pop_empty, clock, reset, pop |-> q_stat.valid, "pop from empty queue")

endmodule

/* sv/exptok_back.sv */
// ----------------------------------------------------------------------------
// exptok_back
// Back end: walks the tokens of the head entry and drives the result
// output register, one token per transfer.
// ----------------------------------------------------------------------------
`include "expression_tokenizer_defines.svh"

module exptok_back
   import exptok_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qstat_type q_stat,
   input  entry_type head,
   output logic      pop,
   input  logic      rsp_ready,
   output logic      rsp_valid,
   output tok_type   rsp_tok,
   output logic      rsp_run_last,
   output logic      rsp_expr_last
);

   logic    sel_ff, sel_in;
   logic    valid_ff, valid_in;
   tok_type tok_ff;
   logic    run_last_ff, expr_last_ff;
   logic    load, last;
   tok_type cur_tok;

   // output register takes a token when empty or being drained
   assign load    = q_stat.valid && (!valid_ff || rsp_ready);
   assign cur_tok = sel_ff ? head.second_tok : head.first_tok;
   assign last    = sel_ff || !head.two_tok;
   assign pop     = load && last;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = !last;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff       <= cur_tok;
         run_last_ff  <= last;
         expr_last_ff <= last && head.expr_end;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_tok       = tok_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_expr_last = expr_last_ff;

   `EXPTOK_ASSERT(a_expr_last_marks_run, clock, reset, valid_ff |-> (run_last_ff || !expr_last_ff), "expression end flagged on a token that is not the last of its character")
   `EXPTOK_ASSERT(a_second_has_head, clock, reset, sel_ff |-> q_stat.valid, "second token pending with no head entry")

endmodule
